// File: design/version_string_parser_unit_assert.svh
// Assertion macros shared by the version string parser modules.
`ifndef VERSION_STRING_PARSER_UNIT_ASSERT_SVH
`define VERSION_STRING_PARSER_UNIT_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define VSP_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// A trigger that forces a condition at the following clock edge.
`define VSP_ASSERT_NEXT(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

// File: design/vsp_pkg.sv
// Shared types and constants of the version string parser.
`timescale 1ns / 1ps

package vsp_pkg;

    // Character codes used by the classifier.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_F  = 8'h66;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_F  = 8'h46;
    localparam logic [7:0] CH_LC_X  = 8'h78;
    localparam logic [7:0] CH_UC_X  = 8'h58;

    // The literal that introduces the beta number.
    localparam int          LIT_LEN = 6;
    localparam logic [7:0]  BETA_LIT [LIT_LEN] = '{8'h2D, 8'h62, 8'h65, 8'h74, 8'h61, 8'h2E};

    // Decimal fields above this limit are rejected.
    localparam logic [31:0] DEC_LIMIT = 32'd254;

    // Version word: major, minor, patch, beta in the low bytes, stamp on top.
    localparam logic [63:0] VERSION_NONE = 64'hFFFF_FFFF_FF00_0000;
    localparam logic [31:0] STAMP_NONE   = 32'hFFFF_FFFF;

    // Register indexes.
    localparam logic REG_TIMESTAMP_MODE = 1'b0;

    // One classified byte.
    typedef struct packed {
        logic                 mode;
        logic                 is_nul;
        logic                 is_dec;
        logic                 is_hexl;
        logic [3:0]           digit;
        logic                 is_ws;
        logic                 is_plus;
        logic                 is_minus;
        logic                 is_dot;
        logic                 is_x;
        logic [LIT_LEN-1:0]   lit_hit;
    } t_token;

    // One result word.
    typedef struct packed {
        logic        ok;
        logic [63:0] version;
    } t_result;

endpackage

// File: design/vsp_fifo.sv
// Small synchronous queue used between the parser stages.
`timescale 1ns / 1ps

module vsp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);

    // DEPTH must be at least two so that the pointers have a bit.
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST  = PW'(DEPTH - 1);
    localparam logic [CW-1:0] C_MAX = CW'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wptr, n_wptr;
    logic [PW-1:0]    r_rptr, n_rptr;
    logic [CW-1:0]    r_count, n_count;
    logic             wr_en, rd_en;

    assign o_full  = (r_count == C_MAX);
    assign o_empty = (r_count == '0);
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rptr];

    // Pointer and fill count update.
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (wr_en) begin
            n_wptr = (r_wptr == LAST) ? '0 : r_wptr + 1'b1;
        end
        if (rd_en) begin
            n_rptr = (r_rptr == LAST) ? '0 : r_rptr + 1'b1;
        end
        if (wr_en && !rd_en) begin
            n_count = r_count + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Storage; entries need no reset.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

`include "version_string_parser_unit_assert.svh"

    `VSP_ASSERT_ALWAYS(a_count_bound, r_count <= C_MAX, "queue count beyond depth")
    `VSP_ASSERT_NEXT(a_count_up, wr_en && !rd_en, r_count == $past(r_count) + 1'b1, "count did not rise on write")

endmodule

// File: design/vsp_front.sv
// Front stage: classifies each incoming byte into a token.
`timescale 1ns / 1ps

module vsp_front
    import vsp_pkg::*;
(
    input  logic [7:0] i_char,
    input  logic       i_mode,
    output t_token     o_token
);

    logic is_dec, is_lc, is_uc;

    assign is_dec = (i_char >= CH_ZERO) && (i_char <= CH_NINE);
    assign is_lc  = (i_char >= CH_LC_A) && (i_char <= CH_LC_F);
    assign is_uc  = (i_char >= CH_UC_A) && (i_char <= CH_UC_F);

    // Character classes and the digit value for both bases.
    always_comb begin
        o_token.mode     = i_mode;
        o_token.is_nul   = (i_char == CH_NUL);
        o_token.is_dec   = is_dec;
        o_token.is_hexl  = is_lc || is_uc;
        if (is_lc) begin
            o_token.digit = 4'(i_char - CH_LC_A + 8'd10);
        end else if (is_uc) begin
            o_token.digit = 4'(i_char - CH_UC_A + 8'd10);
        end else begin
            o_token.digit = 4'(i_char - CH_ZERO);
        end
        o_token.is_ws    = (i_char == CH_SPACE) || ((i_char >= CH_TAB) && (i_char <= CH_CR));
        o_token.is_plus  = (i_char == CH_PLUS);
        o_token.is_minus = (i_char == CH_MINUS);
        o_token.is_dot   = (i_char == CH_DOT);
        o_token.is_x     = (i_char == CH_LC_X) || (i_char == CH_UC_X);
        for (int i = 0; i < LIT_LEN; i++) begin
            o_token.lit_hit[i] = (i_char == BETA_LIT[i]);
        end
    end

endmodule

// File: design/vsp_back.sv
// Back stage: the parser state machine with the digit accumulator.
`timescale 1ns / 1ps

module vsp_back
    import vsp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_tok_valid,
    input  t_token  i_tok,
    output logic    o_tok_pop,
    input  logic    i_res_full,
    output logic    o_res_push,
    output t_result o_res
);

    // Parser phases.
    localparam logic [2:0] PH_MAJOR = 3'd0;
    localparam logic [2:0] PH_MINOR = 3'd1;
    localparam logic [2:0] PH_PATCH = 3'd2;
    localparam logic [2:0] PH_LIT   = 3'd3;
    localparam logic [2:0] PH_BETA  = 3'd4;
    localparam logic [2:0] PH_STAMP = 3'd5;
    localparam logic [2:0] PH_OK    = 3'd6;

    logic [2:0]  r_phase, n_phase;
    logic [31:0] r_accum, n_accum;
    logic        r_started, n_started;
    logic        r_dig, n_dig;
    logic        r_neg, n_neg;
    logic        r_ovf, n_ovf;
    logic        r_pfx, n_pfx;
    logic [2:0]  r_lpos, n_lpos;
    logic        r_failed, n_failed;
    logic [63:0] r_cand, n_cand;
    logic [63:0] r_stored, n_stored;

    logic        step, base16, is_digit, marker_hit, ok;
    logic [35:0] mac;
    logic [31:0] value;

    assign o_tok_pop  = i_tok_valid && !i_res_full;
    assign step       = o_tok_pop;
    assign o_res_push = step && i_tok.is_nul;

    assign base16   = (r_phase == PH_STAMP);
    assign is_digit = i_tok.is_dec || (base16 && i_tok.is_hexl);

    // Multiply-accumulate by ten or sixteen, kept wide to see overflow.
    assign mac = base16 ? ({r_accum, 4'b0000} + 36'(i_tok.digit))
                        : ({1'b0, r_accum, 3'b000} + {3'b000, r_accum, 1'b0}
                           + 36'(i_tok.digit));

    // Converted value of the current field.
    assign value = r_ovf ? STAMP_NONE : (r_neg ? (32'd0 - r_accum) : r_accum);

    // End-of-version marker: plus in timestamp mode, else the terminator.
    assign marker_hit = i_tok.mode ? i_tok.is_plus : i_tok.is_nul;

    // Per-byte parser step.
    always_comb begin
        n_phase   = r_phase;
        n_accum   = r_accum;
        n_started = r_started;
        n_dig     = r_dig;
        n_neg     = r_neg;
        n_ovf     = r_ovf;
        n_pfx     = r_pfx;
        n_lpos    = r_lpos;
        n_failed  = r_failed;
        n_cand    = r_cand;
        n_stored  = r_stored;
        ok        = 1'b0;
        if (step) begin
            if (r_failed) begin
                n_failed = 1'b1;
            end else if (r_phase == PH_LIT) begin
                if ((r_lpos < 3'(LIT_LEN)) && i_tok.lit_hit[r_lpos]) begin
                    n_lpos = r_lpos + 1'b1;
                    if (r_lpos == 3'(LIT_LEN - 1)) begin
                        n_phase   = PH_BETA;
                        n_accum   = '0;
                        n_started = 1'b0;
                        n_dig     = 1'b0;
                        n_neg     = 1'b0;
                        n_ovf     = 1'b0;
                        n_pfx     = 1'b0;
                        n_lpos    = '0;
                    end
                end else begin
                    n_failed = 1'b1;
                end
            end else if (r_phase > PH_STAMP) begin
                n_failed = 1'b1;
            end else if (is_digit) begin
                n_accum   = mac[31:0];
                n_ovf     = r_ovf || (mac[35:32] != 4'd0);
                n_started = 1'b1;
                n_dig     = 1'b1;
                if (r_lpos != 3'd7) begin
                    n_lpos = r_lpos + 1'b1;
                end
            end else if (!r_started && i_tok.is_ws) begin
                n_failed = 1'b0;
            end else if (!r_started && (i_tok.is_plus || i_tok.is_minus)) begin
                n_started = 1'b1;
                n_neg     = i_tok.is_minus;
            end else if (base16 && i_tok.is_x && r_dig && !r_pfx && (r_lpos == 3'd1)
                         && (r_accum == '0)) begin
                // Hex prefix after a single leading zero.
                n_dig  = 1'b0;
                n_pfx  = 1'b1;
                n_lpos = '0;
            end else if (!r_dig) begin
                n_failed = 1'b1;
            end else if (base16) begin
                if (i_tok.is_nul) begin
                    n_cand[63:32] = value;
                    n_phase       = PH_OK;
                end else begin
                    n_failed = 1'b1;
                end
            end else if (value > DEC_LIMIT) begin
                n_failed = 1'b1;
            end else begin
                case (r_phase)
                    PH_MAJOR, PH_MINOR: begin
                        if (r_phase == PH_MAJOR) begin
                            n_cand[7:0] = value[7:0];
                        end else begin
                            n_cand[15:8] = value[7:0];
                        end
                        if (i_tok.is_dot) begin
                            n_phase   = r_phase + 1'b1;
                            n_accum   = '0;
                            n_started = 1'b0;
                            n_dig     = 1'b0;
                            n_neg     = 1'b0;
                            n_ovf     = 1'b0;
                            n_pfx     = 1'b0;
                            n_lpos    = '0;
                        end else begin
                            n_failed = 1'b1;
                        end
                    end
                    default: begin
                        if (r_phase == PH_PATCH) begin
                            n_cand[23:16] = value[7:0];
                        end else begin
                            n_cand[31:24] = value[7:0];
                        end
                        if ((r_phase == PH_PATCH) && i_tok.is_minus) begin
                            // Dash already matches the first literal character.
                            n_phase = PH_LIT;
                            n_lpos  = 3'd1;
                        end else if (!marker_hit) begin
                            n_failed = 1'b1;
                        end else if (i_tok.mode) begin
                            n_phase   = PH_STAMP;
                            n_accum   = '0;
                            n_started = 1'b0;
                            n_dig     = 1'b0;
                            n_neg     = 1'b0;
                            n_ovf     = 1'b0;
                            n_pfx     = 1'b0;
                            n_lpos    = '0;
                        end else begin
                            n_cand[63:32] = STAMP_NONE;
                            n_phase       = PH_OK;
                        end
                    end
                endcase
            end

            // Terminator: report, store on success and start a new string.
            if (i_tok.is_nul) begin
                ok = !n_failed && (n_phase == PH_OK);
                if (ok) begin
                    n_stored = n_cand;
                end
                n_phase   = PH_MAJOR;
                n_accum   = '0;
                n_started = 1'b0;
                n_dig     = 1'b0;
                n_neg     = 1'b0;
                n_ovf     = 1'b0;
                n_pfx     = 1'b0;
                n_lpos    = '0;
                n_failed  = 1'b0;
                n_cand    = VERSION_NONE;
            end
        end
    end

    assign o_res.ok      = ok;
    assign o_res.version = n_stored;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_MAJOR;
            r_accum   <= '0;
            r_started <= 1'b0;
            r_dig     <= 1'b0;
            r_neg     <= 1'b0;
            r_ovf     <= 1'b0;
            r_pfx     <= 1'b0;
            r_lpos    <= '0;
            r_failed  <= 1'b0;
            r_cand    <= VERSION_NONE;
            r_stored  <= VERSION_NONE;
        end else begin
            r_phase   <= n_phase;
            r_accum   <= n_accum;
            r_started <= n_started;
            r_dig     <= n_dig;
            r_neg     <= n_neg;
            r_ovf     <= n_ovf;
            r_pfx     <= n_pfx;
            r_lpos    <= n_lpos;
            r_failed  <= n_failed;
            r_cand    <= n_cand;
            r_stored  <= n_stored;
        end
    end

`include "version_string_parser_unit_assert.svh"

    `VSP_ASSERT_ALWAYS(a_push_on_nul, !o_res_push || (i_tok_valid && i_tok.is_nul), "result without terminator")
    `VSP_ASSERT_NEXT(a_restart, o_res_push, (r_phase == PH_MAJOR) && !r_failed, "parser did not restart after terminator")

endmodule

// File: design/version_string_parser_unit.sv
// Throughput: one byte per cycle, held while the result queue is full.
// The NUL is queued, then its result word is written to the result queue (empty low).
// Queues of TOKEN_DEPTH and RESULT_DEPTH words decouple the input and the result sides.
// Reset is synchronous, active low: queues empty, timestamp mode zero,
// stored version 0.0.0 with no beta and no timestamp.
`timescale 1ns / 1ps

module version_string_parser_unit
    import vsp_pkg::*;
#(
    parameter int TOKEN_DEPTH  = 2,
    parameter int RESULT_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input queue side.
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_char_in,
    // Result queue side.
    output logic        empty,
    input  logic        pop,
    output logic        o_parse_ok,
    output logic [7:0]  o_major_out,
    output logic [7:0]  o_minor_out,
    output logic [7:0]  o_patch_out,
    output logic [7:0]  o_beta_out,
    output logic [31:0] o_stamp_out,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic    r_mode;
    t_token  front_tok, tok_head;
    logic    tok_empty, tok_pop;
    logic    res_full, res_push;
    t_result res_in, res_head;

    // Configuration register.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_TIMESTAMP_MODE) ? {31'd0, r_mode} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_TIMESTAMP_MODE)) begin
            r_mode <= pwdata[0];
        end
    end

    // Front: byte classification.
    vsp_front u_front (
        .i_char  (i_char_in),
        .i_mode  (r_mode),
        .o_token (front_tok)
    );

    // Token queue between front and back.
    vsp_fifo #(
        .WIDTH ($bits(t_token)),
        .DEPTH (TOKEN_DEPTH)
    ) u_tok_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (push),
        .i_wdata (front_tok),
        .o_full  (full),
        .i_rd    (tok_pop),
        .o_rdata (tok_head),
        .o_empty (tok_empty)
    );

    // Back: parser.
    vsp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_valid (!tok_empty),
        .i_tok       (tok_head),
        .o_tok_pop   (tok_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (res_in)
    );

    // Result queue toward the consumer.
    vsp_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (RESULT_DEPTH)
    ) u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (res_push),
        .i_wdata (res_in),
        .o_full  (res_full),
        .i_rd    (pop),
        .o_rdata (res_head),
        .o_empty (empty)
    );

    // Result word fields.
    assign o_parse_ok  = res_head.ok;
    assign o_major_out = res_head.version[7:0];
    assign o_minor_out = res_head.version[15:8];
    assign o_patch_out = res_head.version[23:16];
    assign o_beta_out  = res_head.version[31:24];
    assign o_stamp_out = res_head.version[63:32];

endmodule

// File: test/vsp_result_monitor.sv
// Monitor that predicts the version parser's result words and checks every popped word.
`timescale 1ns / 1ps

module vsp_result_monitor
    import vsp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic        i_full,
    input  logic [7:0]  i_char_in,
    input  logic        i_empty,
    input  logic        i_pop,
    input  logic        i_parse_ok,
    input  logic [7:0]  i_major_out,
    input  logic [7:0]  i_minor_out,
    input  logic [7:0]  i_patch_out,
    input  logic [7:0]  i_beta_out,
    input  logic [31:0] i_stamp_out,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic [31:0] i_prdata,
    input  logic        i_pready,
    output int          o_fail_count,
    output int          o_pending
);

    localparam logic [2:0] MODE_ADDR = 3'(4 * int'(REG_TIMESTAMP_MODE));

    // Which part of the string the parser is in.
    typedef enum logic [2:0] {
        SEG_MAJOR, SEG_MINOR, SEG_PATCH, SEG_LITERAL, SEG_BETA, SEG_STAMP, SEG_DONE
    } t_seg;

    // Predicted parser state and register copy.
    logic        stamp_mode;
    t_seg        seg;
    logic [31:0] accum;
    logic        started, has_digit, negative, overflow, prefixed;
    logic [2:0]  run_len;
    logic        rejected;
    logic [63:0] draft;
    logic [63:0] kept;
    t_result     awaited_versions[$];

    // Prints one line for a mismatch and counts it.
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        o_fail_count++;
        $display("%0t ns: mismatch on %s: got %0h, predicted %0h", $time, what, got, want);
    endtask

    task automatic open_field(input t_seg s);
        seg       = s;
        accum     = '0;
        started   = 1'b0;
        has_digit = 1'b0;
        negative  = 1'b0;
        overflow  = 1'b0;
        prefixed  = 1'b0;
        run_len   = '0;
    endtask

    task automatic open_string();
        open_field(SEG_MAJOR);
        rejected = 1'b0;
        draft    = VERSION_NONE;
    endtask

    // Converted value of the current field, saturated or negated as strtoul does.
    function automatic logic [31:0] field_number();
        if (overflow) begin
            return STAMP_NONE;
        end
        if (negative) begin
            return 32'd0 - accum;
        end
        return accum;
    endfunction

    function automatic int digit_value(input logic [7:0] c, input logic hex);
        if (c >= CH_ZERO && c <= CH_NINE) begin
            return int'(c - CH_ZERO);
        end
        if (hex && c >= CH_LC_A && c <= CH_LC_F) begin
            return int'(c - CH_LC_A) + 10;
        end
        if (hex && c >= CH_UC_A && c <= CH_UC_F) begin
            return int'(c - CH_UC_A) + 10;
        end
        return -1;
    endfunction

    // The byte after the version: a plus in timestamp mode, else the terminator.
    task automatic end_version(input logic [7:0] c);
        if (c != (stamp_mode ? CH_PLUS : CH_NUL)) begin
            rejected = 1'b1;
        end else if (stamp_mode) begin
            open_field(SEG_STAMP);
        end else begin
            draft[63:32] = STAMP_NONE;
            seg          = SEG_DONE;
        end
    endtask

    // One parser step for one accepted byte.
    task automatic parse_byte(input logic [7:0] c);
        int          d;
        logic        hex;
        logic [63:0] t;
        logic [31:0] v;
        if (rejected) begin
            return;
        end
        if (seg == SEG_LITERAL) begin
            if (run_len < LIT_LEN && c == BETA_LIT[run_len]) begin
                run_len++;
                if (run_len == LIT_LEN) begin
                    open_field(SEG_BETA);
                end
            end else begin
                rejected = 1'b1;
            end
            return;
        end
        if (seg == SEG_DONE) begin
            rejected = 1'b1;
            return;
        end
        hex = (seg == SEG_STAMP);
        d   = digit_value(c, hex);
        // Digits accumulate with a sticky overflow flag.
        if (d >= 0) begin
            t = {32'd0, accum} * (hex ? 64'd16 : 64'd10) + 64'(d);
            if (t[63:32] != '0) begin
                overflow = 1'b1;
            end
            accum     = t[31:0];
            started   = 1'b1;
            has_digit = 1'b1;
            if (run_len < 3'd7) begin
                run_len++;
            end
            return;
        end
        // Leading whitespace and one sign before the digits.
        if (!started) begin
            if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
                return;
            end
            if (c == CH_PLUS || c == CH_MINUS) begin
                started  = 1'b1;
                negative = (c == CH_MINUS);
                return;
            end
        end
        // A 0x prefix right after a single leading zero of the timestamp.
        if (hex && (c == CH_LC_X || c == CH_UC_X) && has_digit && !prefixed &&
            run_len == 3'd1 && accum == '0) begin
            has_digit = 1'b0;
            prefixed  = 1'b1;
            run_len   = '0;
            return;
        end
        if (!has_digit) begin
            rejected = 1'b1;
            return;
        end
        v = field_number();
        if (hex) begin
            if (c == CH_NUL) begin
                draft[63:32] = v;
                seg          = SEG_DONE;
            end else begin
                rejected = 1'b1;
            end
            return;
        end
        if (v > DEC_LIMIT) begin
            rejected = 1'b1;
            return;
        end
        // Store the decimal field and move on by its separator.
        case (seg)
            SEG_MAJOR, SEG_MINOR: begin
                draft[8 * int'(seg) +: 8] = v[7:0];
                if (c == CH_DOT) begin
                    open_field(t_seg'(seg + 3'd1));
                end else begin
                    rejected = 1'b1;
                end
            end
            SEG_PATCH: begin
                draft[23:16] = v[7:0];
                if (c == CH_MINUS) begin
                    seg     = SEG_LITERAL;
                    run_len = 3'd1;
                end else begin
                    end_version(c);
                end
            end
            default: begin
                draft[31:24] = v[7:0];
                end_version(c);
            end
        endcase
    endtask

    // Compare popped words, predict pushed bytes, and follow the register port.
    always @(posedge i_clk) begin
        t_result want;
        logic    ok;
        if (!i_rst_n) begin
            stamp_mode   = 1'b0;
            kept         = VERSION_NONE;
            o_fail_count = 0;
            awaited_versions.delete();
            open_string();
        end else begin
            if (i_pop && !i_empty) begin
                if (awaited_versions.size() == 0) begin
                    report_mismatch("result word with nothing awaited", {63'd0, i_parse_ok}, '0);
                end else begin
                    want = awaited_versions.pop_front();
                    if (i_parse_ok !== want.ok) begin
                        report_mismatch("parse_ok", 64'(i_parse_ok), 64'(want.ok));
                    end
                    if (i_major_out !== want.version[7:0]) begin
                        report_mismatch("major", 64'(i_major_out), 64'(want.version[7:0]));
                    end
                    if (i_minor_out !== want.version[15:8]) begin
                        report_mismatch("minor", 64'(i_minor_out), 64'(want.version[15:8]));
                    end
                    if (i_patch_out !== want.version[23:16]) begin
                        report_mismatch("patch", 64'(i_patch_out), 64'(want.version[23:16]));
                    end
                    if (i_beta_out !== want.version[31:24]) begin
                        report_mismatch("beta", 64'(i_beta_out), 64'(want.version[31:24]));
                    end
                    if (i_stamp_out !== want.version[63:32]) begin
                        report_mismatch("stamp", 64'(i_stamp_out), 64'(want.version[63:32]));
                    end
                end
            end
            if (i_push && !i_full) begin
                parse_byte(i_char_in);
                if (i_char_in == CH_NUL) begin
                    ok = !rejected && seg == SEG_DONE;
                    if (ok) begin
                        kept = draft;
                    end
                    want.ok      = ok;
                    want.version = kept;
                    awaited_versions.push_back(want);
                    open_string();
                end
            end
            if (i_psel && i_penable && i_pready && i_paddr == MODE_ADDR) begin
                if (i_pwrite) begin
                    stamp_mode = i_pwdata[0];
                end else if (i_prdata !== {31'd0, stamp_mode}) begin
                    report_mismatch("mode register read", 64'(i_prdata), 64'(stamp_mode));
                end
            end
        end
        o_pending = awaited_versions.size();
    end

endmodule

// File: test/tb.sv
// Testbench top: drives version strings and mode writes into the parser and gives the verdict.
`timescale 1ns / 1ps

module tb;
    import vsp_pkg::*;

    localparam logic [2:0] MODE_ADDR   = 3'(4 * int'(REG_TIMESTAMP_MODE));
    localparam int         PHASE_BYTES = 400;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [7:0]  i_char_in;
    logic        empty;
    logic        pop;
    logic        o_parse_ok;
    logic [7:0]  o_major_out;
    logic [7:0]  o_minor_out;
    logic [7:0]  o_patch_out;
    logic [7:0]  o_beta_out;
    logic [31:0] o_stamp_out;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          fail_count;
    int          pending;
    int          tx_idle_pct;
    int          rx_stall_pct;
    bit          hold_req;
    logic        cur_mode;
    logic [7:0]  text_q[$];

    version_string_parser_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_char_in   (i_char_in),
        .empty       (empty),
        .pop         (pop),
        .o_parse_ok  (o_parse_ok),
        .o_major_out (o_major_out),
        .o_minor_out (o_minor_out),
        .o_patch_out (o_patch_out),
        .o_beta_out  (o_beta_out),
        .o_stamp_out (o_stamp_out),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    vsp_result_monitor u_monitor (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_char_in    (i_char_in),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_parse_ok   (o_parse_ok),
        .i_major_out  (o_major_out),
        .i_minor_out  (o_minor_out),
        .i_patch_out  (o_patch_out),
        .i_beta_out   (o_beta_out),
        .i_stamp_out  (o_stamp_out),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (prdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Run limit.
    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    // Result side: random stalls, plus one long hold-off on request.
    initial begin
        int left;
        left = 0;
        pop  = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                left     = 400;
            end
            if (left > 0) begin
                left--;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(0, 99) >= rx_stall_pct);
            end
        end
    end

    // Offers one byte and returns at the falling edge after it was taken.
    task automatic send_byte(input logic [7:0] c);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push      <= 1'b1;
        i_char_in <= c;
        do @(posedge i_clk); while (full);
        @(negedge i_clk);
    endtask

    task automatic send_text(input string s, input bit terminate);
        for (int i = 0; i < s.len(); i++) begin
            send_byte(s[i]);
        end
        if (terminate) begin
            send_byte(CH_NUL);
        end
    endtask

    // Stops offering and waits until every predicted result word has been popped.
    task automatic drain();
        push <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
    endtask

    // One register access: setup cycle, then access cycle until pready.
    task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Mode change once the parser is idle; the read back is checked by the monitor.
    task automatic set_mode(input logic m);
        drain();
        repeat (8) @(negedge i_clk);
        apb_access(1'b1, MODE_ADDR, {31'd0, m});
        apb_access(1'b0, MODE_ADDR, '0);
        cur_mode = m;
    endtask

    function automatic void put_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            text_q.push_back(s[i]);
        end
    endfunction

    function automatic void put_space();
        int r;
        if ($urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(1, 2)) begin
                r = $urandom_range(0, 5);
                text_q.push_back(r == 0 ? CH_SPACE : CH_TAB + 8'(r - 1));
            end
        end
    endfunction

    // A decimal field: mostly in range, with signs, zeros, large values and overflow mixed in.
    function automatic void put_decimal();
        int              kind;
        int              s;
        longint unsigned v;
        kind = $urandom_range(0, 99);
        put_space();
        if (kind < 1) begin
            return;
        end
        if (kind < 5) begin
            put_text("-0");
            return;
        end
        s = $urandom_range(0, 99);
        if (s < 5) begin
            text_q.push_back(CH_PLUS);
        end else if (s < 7) begin
            text_q.push_back(CH_MINUS);
        end
        if (kind < 8) begin
            v = $urandom_range(255, 9999);
        end else if (kind < 10) begin
            v = {$urandom, $urandom};
        end else if (kind < 17) begin
            put_text("00");
            v = $urandom_range(0, 254);
        end else begin
            v = $urandom_range(0, 254);
        end
        put_text($sformatf("%0d", v));
    endfunction

    // A hex timestamp: optional sign and prefix, up to twelve digits in mixed case.
    function automatic void put_hex();
        int         s;
        int         n;
        int         nib;
        logic [7:0] ch;
        put_space();
        s = $urandom_range(0, 99);
        if (s < 5) begin
            text_q.push_back(CH_PLUS);
        end else if (s < 10) begin
            text_q.push_back(CH_MINUS);
        end
        if ($urandom_range(0, 99) < 30) begin
            text_q.push_back(CH_ZERO);
            text_q.push_back($urandom_range(0, 1) ? CH_LC_X : CH_UC_X);
        end
        s = $urandom_range(0, 99);
        if (s < 3) begin
            n = 0;
        end else if (s < 10) begin
            n = $urandom_range(9, 12);
        end else begin
            n = $urandom_range(1, 8);
        end
        repeat (n) begin
            nib = $urandom_range(0, 15);
            if (nib < 10) begin
                ch = CH_ZERO + 8'(nib);
            end else begin
                ch = ($urandom_range(0, 1) ? CH_UC_A : CH_LC_A) + 8'(nib - 10);
            end
            text_q.push_back(ch);
        end
    endfunction

    // One random string: mostly well formed for the current mode, some noise and damage.
    function automatic void make_string();
        int  pos;
        bit  with_stamp;
        text_q.delete();
        if ($urandom_range(0, 99) < 5) begin
            repeat ($urandom_range(0, 12)) begin
                text_q.push_back(8'($urandom_range(1, 255)));
            end
            text_q.push_back(CH_NUL);
            return;
        end
        put_decimal();
        text_q.push_back(CH_DOT);
        put_decimal();
        text_q.push_back(CH_DOT);
        put_decimal();
        if ($urandom_range(0, 99) < 40) begin
            put_text("-beta.");
            put_decimal();
        end
        with_stamp = cur_mode;
        if ($urandom_range(0, 99) < 5) begin
            with_stamp = !with_stamp;
        end
        if (with_stamp) begin
            text_q.push_back(CH_PLUS);
            put_hex();
        end
        // Damage: replace, drop or insert one byte, or cut the string short.
        if ($urandom_range(0, 99) < 10) begin
            pos = $urandom_range(0, text_q.size() - 1);
            case ($urandom_range(0, 3))
                0: text_q[pos] = 8'($urandom_range(1, 255));
                1: text_q.delete(pos);
                2: text_q.insert(pos, 8'($urandom_range(1, 255)));
                default: begin
                    while (text_q.size() > pos) begin
                        void'(text_q.pop_back());
                    end
                end
            endcase
        end
        text_q.push_back(CH_NUL);
    endfunction

    // Stimulus: reset, directed strings in both modes, then the random phases.
    initial begin
        int phase_bytes;
        bit paused;
        i_rst_n      = 1'b0;
        push         = 1'b0;
        i_char_in    = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_req     = 1'b0;
        cur_mode     = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed strings with the mode at its reset value.
        send_text("", 1'b1);
        send_text("254.0.1", 1'b1);
        send_text(" \011+1.-0.\0159-beta.0", 1'b1);
        send_text("1.2.3-beta.254", 1'b1);
        send_text("255.0.0", 1'b1);
        send_text("4294967296.1.1", 1'b1);
        send_text("1.2", 1'b1);
        send_text("1.2.3+1", 1'b1);
        send_text("1.x.\3773", 1'b1);
        send_text("-1.0.0", 1'b1);
        send_text("1.2.3-beta", 1'b1);

        // Mode switched in the middle of a string, then the timestamp cases.
        send_text("7.8.9", 1'b0);
        set_mode(1'b1);
        send_text("+0xDEADbeef", 1'b1);
        send_text("1.2.3-beta.7+-1", 1'b1);
        send_text("1.2.3+0x", 1'b1);
        send_text("1.2.3+123456789", 1'b1);
        send_text("1.2.3", 1'b1);
        send_text("0.0.0+0X0", 1'b1);

        // Random phases with different idling on both sides.
        for (int ph = 0; ph < 5; ph++) begin
            set_mode(logic'(ph % 2));
            case (ph)
                1:       begin tx_idle_pct = 81; rx_stall_pct = 0;  end
                2:       begin tx_idle_pct = 0;  rx_stall_pct = 81; end
                3:       begin tx_idle_pct = 28; rx_stall_pct = 28; end
                default: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            endcase
            if (ph == 4) begin
                hold_req = 1'b1;
            end
            phase_bytes = 0;
            paused      = 1'b0;
            while (phase_bytes < PHASE_BYTES) begin
                make_string();
                foreach (text_q[i]) begin
                    send_byte(text_q[i]);
                end
                phase_bytes += text_q.size();
                if (!paused && phase_bytes >= PHASE_BYTES / 2) begin
                    paused = 1'b1;
                    drain();
                end
            end
        end

        // Wait for the last result words, then let the pipeline settle.
        push <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// File: version_string_parser_unit.f
+incdir+design
design/vsp_pkg.sv
design/vsp_fifo.sv
design/vsp_front.sv
design/vsp_back.sv
design/version_string_parser_unit.sv
test/vsp_result_monitor.sv
test/tb.sv
